@@ rtl/sm3_pkg.sv @@
// ----------------------------------------------------------------------------
// SM3 hash package
// Item types, initial value, round constants and helper functions shared by the SM3 block.
// ----------------------------------------------------------------------------
`default_nettype none

package sm3_pkg;

    typedef struct packed {
        logic [31:0] message_word;
        logic [2:0]  byte_count;
        logic        last_word;
    } sm3_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        digest_last;
    } sm3_out_t;

    localparam logic [31:0] T_LOW    = 32'h79cc4519;
    localparam logic [31:0] T_HIGH   = 32'h7a879d8a;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    localparam logic [31:0] IV [8] = '{
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
    };

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] p0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] p1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

`default_nettype wire

@@ rtl/sm3_hash.sv @@
// ----------------------------------------------------------------------------
// SM3 hash top level
// Gathers message words into 16-word blocks, pads the message and runs the
// 64-round compression one round per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes message items: one big-endian word, its byte count and a
//   last flag. m_ channel returns eight digest items after each last item,
//   digest_last set on the eighth.
//   A non-last item is taken while idle; the item that fills a block then
//   holds s_ready low for the 64 rounds and the fold of the chain value.
//   The single round unit sets the sustained rate, as no word is taken
//   while a block is compressed.
//   A last item runs padding, one word per cycle outside the compressions,
//   and up to two compressions, then drives eight digest items, one per
//   cycle while m_ready is high. A stalled receiver holds the digest item
//   and the block takes nothing new until all eight are delivered and the
//   initial value is reloaded.
//   The message schedule is a 16-word sliding window; W[j+4] is read from it.
//   Reset (aresetn low, synchronous) loads the initial value, clears the
//   length and word position and returns to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module sm3_hash
    import sm3_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire sm3_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output sm3_out_t      m_data
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PAD   = 6'b000010,
        ST_ROUND = 6'b000100,
        ST_FOLD  = 6'b001000,
        ST_OUT   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    // pad steps: 0x80 marker word, zero fill, length hi, length lo
    typedef enum logic [1:0] {
        PD_PAD80 = 2'd0,
        PD_ZERO  = 2'd1,
        PD_LENHI = 2'd2,
        PD_LENLO = 2'd3
    } pad_t;

    state_t      state_reg, state_next;
    pad_t        pad_reg, pad_next;
    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] s_reg [8];
    logic [3:0]  pos_reg, pos_next;
    logic [63:0] len_reg, len_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [2:0]  oidx_reg, oidx_next;
    logic        fin_reg, fin_next;
    logic [31:0] pad_word_reg, pad_word_next;

    logic        push;
    logic [31:0] push_word;
    logic [2:0]  cnt;
    logic [31:0] keep, tail;
    logic        do_round, do_fold, load_s;

    // round datapath
    logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2, wnew;

    always_comb begin
        cnt  = (s_data.byte_count > 3'd4) ? 3'd4 : s_data.byte_count;
        keep = (cnt == 3'd0) ? 32'd0 : (32'hffffffff << (6'd32 - {cnt, 3'b000}));
        tail = (s_data.message_word & keep)
             | ({24'd0, PAD_BYTE} << (5'd24 - {cnt[1:0], 3'b000}));
    end

    always_comb begin
        tj   = rnd_reg[5:4] == 2'd0 ? T_LOW : T_HIGH;
        a12  = rotl(s_reg[0], 5'd12);
        ss1  = rotl(a12 + s_reg[4] + rotl(tj, rnd_reg[4:0]), 5'd7);
        ss2  = ss1 ^ a12;
        if (rnd_reg[5:4] == 2'd0) begin
            ff = s_reg[0] ^ s_reg[1] ^ s_reg[2];
            gg = s_reg[4] ^ s_reg[5] ^ s_reg[6];
        end else begin
            ff = (s_reg[0] & s_reg[1]) | (s_reg[0] & s_reg[2]) | (s_reg[1] & s_reg[2]);
            gg = (s_reg[4] & s_reg[5]) | (~s_reg[4] & s_reg[6]);
        end
        tt1  = ff + s_reg[3] + ss2 + (w_reg[0] ^ w_reg[4]);
        tt2  = gg + s_reg[7] + ss1 + w_reg[0];
        wnew = p1(w_reg[0] ^ w_reg[7] ^ rotl(w_reg[13], 5'd15))
             ^ rotl(w_reg[3], 5'd7) ^ w_reg[10];
    end

    always_comb begin
        state_next    = state_reg;
        pad_next      = pad_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;
        rnd_next      = rnd_reg;
        oidx_next     = oidx_reg;
        fin_next      = fin_reg;
        pad_word_next = pad_word_reg;
        push          = 1'b0;
        push_word     = 32'd0;
        s_ready       = 1'b0;
        m_valid       = 1'b0;
        do_round      = 1'b0;
        do_fold       = 1'b0;
        load_s        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (!s_data.last_word) begin
                        len_next  = len_reg + 64'd32;
                        push      = 1'b1;
                        push_word = s_data.message_word;
                    end else begin
                        len_next = len_reg + {58'd0, cnt, 3'b000};
                        fin_next = 1'b1;
                        push     = 1'b1;
                        if (cnt == 3'd4) begin
                            push_word     = s_data.message_word;
                            pad_word_next = {PAD_BYTE, 24'd0};
                            pad_next      = PD_PAD80;
                        end else begin
                            push_word = tail;
                            pad_next  = PD_ZERO;
                        end
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                push = 1'b1;
                case (pad_reg)
                    PD_PAD80: begin
                        push_word = pad_word_reg;
                        pad_next  = PD_ZERO;
                    end
                    PD_ZERO: begin
                        if (pos_reg == 4'd14) begin
                            push_word = len_reg[63:32];
                            pad_next  = PD_LENLO;
                        end else begin
                            push_word = 32'd0;
                        end
                    end
                    PD_LENHI: begin
                        push_word = len_reg[63:32];
                        pad_next  = PD_LENLO;
                    end
                    PD_LENLO: begin
                        push_word = len_reg[31:0];
                        fin_next  = 1'b0;
                    end
                    default: push_word = 32'd0;
                endcase
            end
            ST_ROUND: begin
                do_round = 1'b1;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                do_fold = 1'b1;
                if (fin_reg || pad_reg != PD_LENLO) begin
                    state_next = (state_t'(fin_reg ? ST_PAD : ST_IDLE));
                end else begin
                    state_next = ST_OUT;
                    oidx_next  = 3'd0;
                end
                if (pad_reg == PD_LENLO && !fin_reg) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                pos_next   = 4'd0;
                len_next   = 64'd0;
                pad_next   = PD_ZERO;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        if (push) begin
            pos_next = pos_reg + 4'd1;
            if (pos_reg == 4'd15) begin
                load_s     = 1'b1;
                rnd_next   = 6'd0;
                state_next = ST_ROUND;
            end else if (state_reg == ST_PAD && pad_reg == PD_LENLO) begin
                state_next = ST_PAD;
            end
        end
    end

    assign m_data.digest_word = v_reg[oidx_reg];
    assign m_data.digest_last = (oidx_reg == 3'd7);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pad_reg   <= PD_ZERO;
            pos_reg   <= 4'd0;
            len_reg   <= 64'd0;
            rnd_reg   <= 6'd0;
            oidx_reg  <= 3'd0;
            fin_reg   <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                v_reg[i] <= IV[i];
            end
        end else begin
            state_reg <= state_next;
            pad_reg   <= pad_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            rnd_reg   <= rnd_next;
            oidx_reg  <= oidx_next;
            fin_reg   <= fin_next;
            if (do_fold) begin
                for (int i = 0; i < 8; i++) begin
                    v_reg[i] <= v_reg[i] ^ s_reg[i];
                end
            end else if (state_reg == ST_DONE) begin
                for (int i = 0; i < 8; i++) begin
                    v_reg[i] <= IV[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        pad_word_reg <= pad_word_next;
        if (push) begin
            w_reg[pos_reg] <= push_word;
        end else if (do_round) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= wnew;
        end
        if (load_s) begin
            for (int i = 0; i < 8; i++) begin
                s_reg[i] <= v_reg[i];
            end
        end else if (do_round) begin
            s_reg[0] <= tt1;
            s_reg[1] <= s_reg[0];
            s_reg[2] <= rotl(s_reg[1], 5'd9);
            s_reg[3] <= s_reg[2];
            s_reg[4] <= p0(tt2);
            s_reg[5] <= s_reg[4];
            s_reg[6] <= rotl(s_reg[5], 5'd19);
            s_reg[7] <= s_reg[6];
        end
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE)
        else $error("s_ready outside idle");
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and output active together");
    a_round_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && rnd_reg == 6'd63) |=> state_reg == ST_FOLD)
        else $error("round count overrun");
    a_last_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.digest_last) |=> state_reg == ST_DONE)
        else $error("digest end not followed by done");

endmodule

`default_nettype wire
